// ===== rtl/core/kctt_pkg.sv =====
// Package: types and constants of the keyed countdown timer table.
`default_nettype none
package kctt_pkg;
   localparam int Capacity = 16;
   localparam int SlotBits = (Capacity > 1) ? $clog2(Capacity) : 1;
   localparam int CountBits = $clog2(Capacity + 1);
   localparam int QueueDepth = 2;
   localparam int FracOne = 65536;

   localparam logic [2:0] OP_START     = 3'd0;
   localparam logic [2:0] OP_TICK      = 3'd1;
   localparam logic [2:0] OP_RESET_ONE = 3'd2;
   localparam logic [2:0] OP_RESET_ALL = 3'd3;
   localparam logic [2:0] OP_QUERY     = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] tag;
      logic [31:0] time_amount;
   } req_type;

   typedef struct packed {
      logic        running;
      logic [31:0] time_left;
      logic [16:0] fraction_left;
      logic        table_full;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/core/kctt_queue.sv =====
// Small FIFO between the request front end and the table engine.
`default_nettype none
module kctt_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  kctt_pkg::req_type        in_item,
   output logic                     out_valid,
   input  wire                      out_ready,
   output kctt_pkg::req_type        out_item
);
   import kctt_pkg::*;
   localparam int PtrBits = $clog2(QueueDepth);

   req_type               mem_ff [QueueDepth];
   logic [PtrBits-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrBits:0]      cnt_ff, cnt_in;
   logic                  push, pop;

   assign in_ready  = (cnt_ff != (PtrBits+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset)
         cnt_ff <= (PtrBits+1)'(QueueDepth);
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

   property p_count_track;
      @(posedge clock) disable iff (reset)
         (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1);
   endproperty
   a_count_track: assert property (p_count_track) else $error("queue count");

   property p_pop_track;
      @(posedge clock) disable iff (reset)
         (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 1'b1);
   endproperty
   a_pop_track: assert property (p_pop_track) else $error("queue count");
endmodule
`default_nettype wire

// ===== rtl/core/kctt_divider.sv =====
// Restoring divider: floor(rem * 65536 / dur) clamped to one, one bit a cycle.
`default_nettype none
module kctt_divider (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   input  wire  [31:0]  remaining,
   input  wire  [31:0]  duration,
   output logic         done,
   output logic [16:0]  quotient
);
   import kctt_pkg::*;

   logic [31:0] part_ff, part_in;
   logic [16:0] low_ff, low_in;
   logic [16:0] quo_ff, quo_in;
   logic [31:0] div_ff, div_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [32:0] shifted;
   logic [32:0] trial;

   // Dividend is rem<<16. Since remaining <= duration the quotient fits 17 bits,
   // so the top 31 dividend bits start as the partial remainder: 17 steps.
   always_comb begin
      part_in = part_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      shifted = {part_ff, low_ff[16]};
      trial   = shifted - {1'b0, div_ff};
      done    = 1'b0;
      if (start) begin
         part_in = {1'b0, remaining[31:1]};
         low_in  = {remaining[0], 16'd0};
         quo_in  = '0;
         div_in  = duration;
         step_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 5'd17) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end else begin
            if (!trial[32]) begin
               part_in = trial[31:0];
               quo_in  = {quo_ff[15:0], 1'b1};
            end else begin
               part_in = shifted[31:0];
               quo_in  = {quo_ff[15:0], 1'b0};
            end
            low_in  = {low_ff[15:0], 1'b0};
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign quotient = (quo_ff > 17'(FracOne)) ? 17'(FracOne) : quo_ff;
endmodule
`default_nettype wire

// ===== rtl/core/kctt_engine.sv =====
// Table engine: update sweep and lookup sweep per item, then fraction division on a hit, and result.
`default_nettype none
module kctt_engine (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   output logic               in_ready,
   input  kctt_pkg::req_type  in_item,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output kctt_pkg::rsp_type  rsp_data
);
   import kctt_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_APPLY = 3'd2;
   localparam logic [2:0] ST_LOOK  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]           state_ff, state_in;
   req_type              item_ff;
   logic [Capacity-1:0]  valid_ff;
   logic [31:0]          key_mem [Capacity];
   logic [31:0]          rem_mem [Capacity];
   logic [31:0]          dur_mem [Capacity];
   logic [CountBits-1:0] idx_ff;
   logic [SlotBits-1:0]  idx;
   logic                 hit_ff, free_ff;
   logic [SlotBits-1:0]  hit_slot_ff, free_slot_ff;
   logic [31:0]          rem_rd_ff, dur_rd_ff;
   logic                 full_ff;
   logic                 div_done;
   logic [16:0]          div_q;
   logic                 scan_last;

   assign idx       = idx_ff[SlotBits-1:0];
   assign scan_last = (idx_ff == CountBits'(Capacity - 1));
   assign in_ready  = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   // Scan one slot per cycle: key match, first free, tick update and reset-all clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         idx_ff   <= '0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  item_ff <= in_item;
                  idx_ff  <= '0;
                  hit_ff  <= 1'b0;
                  free_ff <= 1'b0;
                  full_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (valid_ff[idx] && key_mem[idx] == item_ff.tag && !hit_ff) begin
                  hit_ff      <= 1'b1;
                  hit_slot_ff <= idx;
               end
               if (!valid_ff[idx] && !free_ff) begin
                  free_ff      <= 1'b1;
                  free_slot_ff <= idx;
               end
               if (item_ff.operation == OP_TICK && item_ff.time_amount != '0
                   && valid_ff[idx]) begin
                  if (rem_mem[idx] <= item_ff.time_amount) begin
                     valid_ff[idx] <= 1'b0;
                  end else begin
                     rem_mem[idx] <= rem_mem[idx] - item_ff.time_amount;
                  end
               end
               if (item_ff.operation == OP_RESET_ALL) begin
                  valid_ff[idx] <= 1'b0;
               end
               if (scan_last) begin
                  state_ff <= ST_APPLY;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_APPLY: begin
               idx_ff <= '0;
               hit_ff <= 1'b0;
               case (item_ff.operation)
                  OP_START: begin
                     if (item_ff.time_amount == '0) begin
                        if (hit_ff) valid_ff[hit_slot_ff] <= 1'b0;
                     end else if (hit_ff) begin
                        rem_mem[hit_slot_ff] <= item_ff.time_amount;
                        dur_mem[hit_slot_ff] <= item_ff.time_amount;
                     end else if (free_ff) begin
                        valid_ff[free_slot_ff] <= 1'b1;
                        key_mem[free_slot_ff]  <= item_ff.tag;
                        rem_mem[free_slot_ff]  <= item_ff.time_amount;
                        dur_mem[free_slot_ff]  <= item_ff.time_amount;
                     end else begin
                        full_ff <= 1'b1;
                     end
                  end
                  OP_RESET_ONE: begin
                     if (hit_ff) valid_ff[hit_slot_ff] <= 1'b0;
                  end
                  default: begin
                  end
               endcase
               state_ff <= ST_LOOK;
            end
            ST_LOOK: begin
               // second pass finds the tag after the update
               if (!hit_ff) begin
                  if (valid_ff[idx] && key_mem[idx] == item_ff.tag) begin
                     hit_ff    <= 1'b1;
                     rem_rd_ff <= rem_mem[idx];
                     dur_rd_ff <= dur_mem[idx];
                     state_ff  <= ST_DIV;
                  end else if (scan_last) begin
                     state_ff <= ST_OUT;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   logic div_go_ff;
   always_ff @(posedge clock) begin
      if (reset) div_go_ff <= 1'b0;
      else div_go_ff <= (state_ff == ST_LOOK) && !hit_ff
                        && valid_ff[idx] && key_mem[idx] == item_ff.tag;
   end

   kctt_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .remaining (rem_rd_ff),
      .duration  (dur_rd_ff),
      .done      (div_done),
      .quotient  (div_q)
   );

   logic [16:0] frac_ff;
   always_ff @(posedge clock) begin
      if (div_done) frac_ff <= div_q;
   end

   always_comb begin
      rsp_data.running       = hit_ff;
      rsp_data.time_left     = hit_ff ? rem_rd_ff : '0;
      rsp_data.fraction_left = hit_ff ? frac_ff : '0;
      rsp_data.table_full    = full_ff;
   end

   property p_full_only_start;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_OUT && full_ff) |-> (item_ff.operation == OP_START);
   endproperty
   a_full_only_start: assert property (p_full_only_start) else $error("bad full flag");

   property p_hold_out;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> rsp_valid;
   endproperty
   a_hold_out: assert property (p_hold_out) else $error("result dropped");

   property p_div_after_hit;
      @(posedge clock) disable iff (reset)
         div_go_ff |-> (state_ff == ST_DIV);
   endproperty
   a_div_after_hit: assert property (p_div_after_hit) else $error("divider start");
endmodule
`default_nettype wire

// ===== rtl/core/keyed_countdown_timer_table_unit.sv =====
// Keyed countdown timer table: front queue plus sequential table engine.
// Each item takes an update sweep, a lookup sweep and, on a hit, a divide; the engine
// takes a new item only after the last result is taken, so items never overlap in it.
// The front queue holds up to two items while the engine works.
// Synchronous active-high reset clears all valid bits and the queue at once.
`default_nettype none
module keyed_countdown_timer_table_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  kctt_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output kctt_pkg::rsp_type  rsp_data
);
   import kctt_pkg::*;

   logic    q_valid, q_ready;
   req_type q_item;

   kctt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   kctt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire
